### src/multiset_duplicate_classifier_defines.svh
// ----------------------------------------------------------------------------
// Multiset duplicate classifier: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MULTISET_DUPLICATE_CLASSIFIER_DEFINES_SVH
`define MULTISET_DUPLICATE_CLASSIFIER_DEFINES_SVH

// Same-cycle implication.
`define MSDC_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define MSDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/msdc_pkg.sv
// ----------------------------------------------------------------------------
// Multiset duplicate classifier package
// Command/status bundles between controller and datapath, opcodes, classes.
// ----------------------------------------------------------------------------
package msdc_pkg;

  localparam int unsigned KEY_BITS = 32;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  localparam logic [1:0] CLASS_NEITHER = 2'd0;
  localparam logic [1:0] CLASS_HOMO    = 2'd1;
  localparam logic [1:0] CLASS_HETERO  = 2'd2;
  localparam logic [1:0] CLASS_BOTH    = 2'd3;

  typedef struct packed {
    logic load_item;
    logic rd_en;
    logic clear_wr;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic match_now;
    logic look_valid;
  } status_t;

  function automatic logic [1:0] class_decide(input logic none, input logic single,
                                              input logic repeated);
    logic [1:0] code;
    if (none) begin
      code = CLASS_NEITHER;
    end else if (single) begin
      code = repeated ? CLASS_HOMO : CLASS_NEITHER;
    end else begin
      code = repeated ? CLASS_BOTH : CLASS_HETERO;
    end
    return code;
  endfunction

endpackage

### src/msdc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module msdc_ram #(
  parameter int unsigned WIDTH = 49,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/msdc_datapath.sv
// ----------------------------------------------------------------------------
// Multiset duplicate classifier datapath
// Entry RAM, key compare on the read stream, count update, totals and class.
// ----------------------------------------------------------------------------
module msdc_datapath #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned COUNT_BITS    = 16,
  localparam int unsigned AW = $clog2(TABLE_ENTRIES)
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  msdc_pkg::cmd_t                       cmd,
  input  logic [AW-1:0]                        idx,
  input  logic                                 op,
  input  logic signed [msdc_pkg::KEY_BITS-1:0] key,
  output msdc_pkg::status_t                    status,
  output logic [1:0]                           class_code,
  output logic                                 overflow
);

  import msdc_pkg::*;

  localparam int unsigned CW     = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned WORD_W = 1 + COUNT_BITS + KEY_BITS;

  logic                  op_r;
  logic [KEY_BITS-1:0]   key_r;
  logic                  look_valid;
  logic [AW-1:0]         look_addr;
  logic [WORD_W-1:0]     rd_data;
  logic                  rd_vld;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic [KEY_BITS-1:0]   rd_key;
  logic                  match_now;
  logic                  free_now;
  logic                  hit;
  logic [AW-1:0]         hit_addr;
  logic [COUNT_BITS-1:0] hit_count;
  logic                  free_found;
  logic [AW-1:0]         free_addr;
  logic [CW-1:0]         distinct_total;
  logic [CW-1:0]         repeated_total;
  logic [CW-1:0]         distinct_next;
  logic [CW-1:0]         repeated_next;
  logic                  upd_we;
  logic [AW-1:0]         upd_addr;
  logic [WORD_W-1:0]     upd_word;
  logic                  ovf_next;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [WORD_W-1:0]     wr_data;

  // word layout: valid, count, key
  assign rd_vld = rd_data[WORD_W-1];
  assign rd_cnt = rd_data[KEY_BITS +: COUNT_BITS];
  assign rd_key = rd_data[KEY_BITS-1:0];

  // ignore reads still in flight once the key is found
  assign match_now = look_valid && !hit && rd_vld && (rd_key == key_r);
  assign free_now  = look_valid && !hit && !free_found && !rd_vld;

  assign status.match_now  = match_now;
  assign status.look_valid = look_valid;

  always_comb begin
    upd_we        = 1'b0;
    upd_addr      = hit_addr;
    upd_word      = '0;
    ovf_next      = 1'b0;
    distinct_next = distinct_total;
    repeated_next = repeated_total;
    if (op_r == OP_INSERT) begin
      if (hit) begin
        if (hit_count == '1) begin
          ovf_next = 1'b1;
        end else begin
          upd_we   = 1'b1;
          upd_word = {1'b1, hit_count + COUNT_BITS'(1), key_r};
          if (hit_count == COUNT_BITS'(1)) begin
            repeated_next = repeated_total + CW'(1);
          end
        end
      end else if (free_found) begin
        upd_we        = 1'b1;
        upd_addr      = free_addr;
        upd_word      = {1'b1, COUNT_BITS'(1), key_r};
        distinct_next = distinct_total + CW'(1);
      end else begin
        ovf_next = 1'b1;
      end
    end else if (hit) begin
      upd_we = 1'b1;
      if (hit_count == COUNT_BITS'(1)) begin
        // free the entry
        upd_word      = '0;
        distinct_next = distinct_total - CW'(1);
      end else begin
        upd_word = {1'b1, hit_count - COUNT_BITS'(1), key_r};
        if (hit_count == COUNT_BITS'(2)) begin
          repeated_next = repeated_total - CW'(1);
        end
      end
    end
  end

  assign wr_en   = cmd.clear_wr || (cmd.commit && upd_we);
  assign wr_addr = cmd.clear_wr ? idx : upd_addr;
  assign wr_data = cmd.clear_wr ? '0 : upd_word;

  msdc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      look_valid     <= 1'b0;
      hit            <= 1'b0;
      free_found     <= 1'b0;
      distinct_total <= '0;
      repeated_total <= '0;
    end else begin
      look_valid <= cmd.rd_en;
      if (cmd.load_item) begin
        hit        <= 1'b0;
        free_found <= 1'b0;
      end else begin
        if (match_now) begin
          hit <= 1'b1;
        end
        if (free_now) begin
          free_found <= 1'b1;
        end
      end
      if (cmd.commit) begin
        distinct_total <= distinct_next;
        repeated_total <= repeated_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      look_addr <= idx;
    end
    if (cmd.load_item) begin
      op_r  <= op;
      key_r <= key;
    end
    if (match_now) begin
      hit_addr  <= look_addr;
      hit_count <= rd_cnt;
    end
    if (free_now) begin
      free_addr <= look_addr;
    end
    if (cmd.commit) begin
      class_code <= class_decide(distinct_next == '0, distinct_next == CW'(1),
                                 repeated_next != '0);
      overflow   <= ovf_next;
    end
  end

endmodule

### src/msdc_ctrl.sv
// ----------------------------------------------------------------------------
// Multiset duplicate classifier controller
// Sequences the clear sweep, the table scan, the update and the output slot.
// ----------------------------------------------------------------------------
`include "multiset_duplicate_classifier_defines.svh"

module msdc_ctrl #(
  parameter int unsigned TABLE_ENTRIES = 64,
  localparam int unsigned AW = $clog2(TABLE_ENTRIES)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output msdc_pkg::cmd_t    cmd,
  output logic [AW-1:0]     idx,
  input  msdc_pkg::status_t status
);

  import msdc_pkg::*;

  localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_CLEAR:  cmd.clear_wr  = 1'b1;
      ST_IDLE:   cmd.load_item = in_valid;
      ST_SCAN:   cmd.rd_en     = 1'b1;
      ST_DRAIN:  cmd           = '0;
      ST_UPDATE: cmd.commit    = out_free;
      default:   cmd           = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          if (idx == LAST) begin
            state <= ST_IDLE;
            idx   <= '0;
          end else begin
            idx <= idx + AW'(1);
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_SCAN;
            idx   <= '0;
          end
        end
        ST_SCAN: begin
          // stop early on a hit; the read still in flight is dropped
          if (status.match_now) begin
            state <= ST_UPDATE;
          end else if (idx == LAST) begin
            state <= ST_DRAIN;
          end else begin
            idx <= idx + AW'(1);
          end
        end
        ST_DRAIN: begin
          state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `MSDC_ASSERT_IMPLIES(a_idle_no_lookup, state == ST_IDLE, !status.look_valid, "lookup pending in idle")
  `MSDC_ASSERT_IMPLIES(a_match_in_search, status.match_now, state == ST_SCAN || state == ST_DRAIN, "match outside search")
  `MSDC_ASSERT_NEXT(a_commit_shows_result, cmd.commit, out_valid, "commit without result")

endmodule

### src/multiset_duplicate_classifier.sv
// ----------------------------------------------------------------------------
// Multiset duplicate classifier: counting multiset table with class output
// Search: a found key ends the table scan early; an absent key scans every entry.
// Items are taken one at a time: in_stall stays high until the result is committed.
// Reset: a clearing pass over every entry of the entry RAM, input stalled.
// ----------------------------------------------------------------------------
module multiset_duplicate_classifier #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned COUNT_BITS    = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 op,
  input  logic signed [msdc_pkg::KEY_BITS-1:0] key,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           class_code,
  output logic                                 overflow
);

  import msdc_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);

  cmd_t          cmd;
  status_t       status;
  logic [AW-1:0] idx;

  msdc_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .idx       (idx),
    .status    (status)
  );

  msdc_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .COUNT_BITS    (COUNT_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .idx        (idx),
    .op         (op),
    .key        (key),
    .status     (status),
    .class_code (class_code),
    .overflow   (overflow)
  );

endmodule

### test/multiset_duplicate_classifier_tb.sv
// ----------------------------------------------------------------------------
// Multiset duplicate classifier testbench
// Drives insert and delete transfers into the counting table and keeps a
// mirror of the table that predicts the class and overflow of every item.
// Covers directed corner keys, fill/drain/churn bursts under three idling
// patterns, full-table overflow and a short repeated-key tail on an empty table.
// ----------------------------------------------------------------------------
module multiset_duplicate_classifier_tb;
  import msdc_pkg::*;

  localparam int ENTRIES      = 64;
  localparam int COUNT_W      = 16;
  localparam int COUNT_TOP    = (1 << COUNT_W) - 1;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = ENTRIES + 8;

  localparam logic [31:0] KEY_MIN      = 32'h8000_0000;
  localparam logic [31:0] KEY_MAX      = 32'h7fff_ffff;
  localparam logic [31:0] KEY_ALL_ONES = 32'hffff_ffff;

  typedef struct packed {
    logic [1:0] code;
    logic       ovf;
  } verdict_t;

  class multiset_mirror;
    logic [31:0] slot_key [ENTRIES];
    int          slot_count [ENTRIES];
    bit          slot_used [ENTRIES];
    int          distinct_keys;
    int          repeated_keys;
    verdict_t    verdict_q [$];
    int          errors;
    int          results;
    int          overflows;
    int          class_seen [4];

    function new();
      for (int i = 0; i < ENTRIES; i++) begin
        slot_key[i]   = '0;
        slot_count[i] = 0;
        slot_used[i]  = 1'b0;
      end
      distinct_keys = 0;
      repeated_keys = 0;
      errors        = 0;
      results       = 0;
      overflows     = 0;
      for (int i = 0; i < 4; i++) class_seen[i] = 0;
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction

    // Random key of a live entry; random value when the table is empty.
    function logic [31:0] pick_key();
      int          start;
      logic [31:0] k;
      start = $urandom_range(ENTRIES - 1);
      k     = $urandom;
      for (int n = 0; n < ENTRIES; n++) begin
        if (slot_used[(start + n) % ENTRIES]) k = slot_key[(start + n) % ENTRIES];
      end
      return k;
    endfunction

    function void note_item(input logic op_i, input logic [31:0] key_i);
      int       hit;
      int       free_slot;
      verdict_t v;
      hit       = -1;
      free_slot = -1;
      v.ovf     = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        if (hit < 0 && slot_used[i] && slot_key[i] == key_i) hit = i;
        if (free_slot < 0 && !slot_used[i]) free_slot = i;
      end
      if (op_i == OP_INSERT) begin
        if (hit >= 0) begin
          if (slot_count[hit] >= COUNT_TOP) begin
            v.ovf = 1'b1;
          end else begin
            slot_count[hit]++;
            if (slot_count[hit] == 2) repeated_keys++;
          end
        end else if (free_slot < 0) begin
          v.ovf = 1'b1;
        end else begin
          slot_used[free_slot]  = 1'b1;
          slot_key[free_slot]   = key_i;
          slot_count[free_slot] = 1;
          distinct_keys++;
        end
      end else if (hit >= 0) begin
        slot_count[hit]--;
        if (slot_count[hit] == 1) repeated_keys--;
        if (slot_count[hit] == 0) begin
          slot_used[hit] = 1'b0;
          distinct_keys--;
        end
      end
      if (distinct_keys == 0) begin
        v.code = CLASS_NEITHER;
      end else if (distinct_keys == 1) begin
        v.code = (repeated_keys > 0) ? CLASS_HOMO : CLASS_NEITHER;
      end else begin
        v.code = (repeated_keys > 0) ? CLASS_BOTH : CLASS_HETERO;
      end
      verdict_q.push_back(v);
    endfunction

    function void check_result(input logic [1:0] code, input logic ovf);
      verdict_t v;
      results++;
      class_seen[code]++;
      if (ovf) overflows++;
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result class_code=%0d overflow=%0b", $time, code, ovf);
        errors++;
        return;
      end
      v = verdict_q.pop_front();
      if (v.code !== code) begin
        $display("%0t: class_code mismatch expected=%0d actual=%0d", $time, v.code, code);
        errors++;
      end
      if (v.ovf !== ovf) begin
        $display("%0t: overflow mismatch expected=%0b actual=%0b", $time, v.ovf, ovf);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               op = OP_INSERT;
  logic signed [31:0] key = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         class_code;
  logic               overflow;

  multiset_mirror mirror;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_sent    = 0;
  int quiet_cycles  = 0;

  multiset_duplicate_classifier #(
    .TABLE_ENTRIES(ENTRIES),
    .COUNT_BITS   (COUNT_W)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .key       (key),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .class_code(class_code),
    .overflow  (overflow)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
  end

  // Check results and watch for a hung handshake.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (out_valid && !out_stall) mirror.check_result(class_code, overflow);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("multiset_duplicate_classifier verification failed");
        $finish;
      end
    end
  end

  // Leave valid high after the transfer; the next call lowers it only to idle.
  task automatic send_item(input logic op_i, input logic [31:0] key_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= op_i;
    key      <= key_i;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    mirror.note_item(op_i, key_i);
    items_sent++;
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (mirror.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] fresh_key();
    logic [31:0] k;
    case ($urandom_range(3))
      0, 1:    k = $urandom;
      2:       k = mirror.pick_key() ^ (32'd1 << $urandom_range(31));
      default: k = $urandom_range(15) ^ {32{1'($urandom_range(1))}};
    endcase
    return k;
  endfunction

  task automatic run_random(input int send_pct, input int recv_pct, input int budget);
    int          target;
    int          pick;
    int          n;
    bit          first;
    logic        op_r;
    logic [31:0] key_r;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    target        = items_sent + budget;
    first         = 1'b1;
    while (items_sent < target) begin
      pick  = first ? 0 : $urandom_range(99);
      first = 1'b0;
      if (pick < 20) begin
        // fill past capacity so inserts into a full table get flagged
        n = ENTRIES - mirror.distinct_keys + $urandom_range(2, 6);
        repeat (n) send_item(OP_INSERT, fresh_key());
      end else if (pick < 35) begin
        n = $urandom_range(10, 60);
        while (n > 0 && mirror.distinct_keys > 0) begin
          send_item(OP_DELETE, mirror.pick_key());
          n--;
        end
      end else if (pick < 88) begin
        repeat ($urandom_range(10, 30)) begin
          op_r  = ($urandom_range(99) < 55) ? OP_INSERT : OP_DELETE;
          key_r = (mirror.distinct_keys > 0 && $urandom_range(99) < 65) ?
                  mirror.pick_key() : fresh_key();
          send_item(op_r, key_r);
        end
      end else begin
        repeat ($urandom_range(4, 10)) begin
          op_r = ($urandom_range(1) == 0) ? OP_INSERT : OP_DELETE;
          case ($urandom_range(4))
            0:       key_r = '0;
            1:       key_r = KEY_MIN;
            2:       key_r = KEY_MAX;
            3:       key_r = KEY_ALL_ONES;
            default: key_r = $urandom;
          endcase
          send_item(op_r, key_r);
        end
      end
      if ($urandom_range(5) == 0) hold_until_drained();
    end
  endtask

  initial begin
    mirror = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed corners, starting from an empty table.
    send_idle_pct = 17;
    recv_idle_pct = 84;
    send_item(OP_DELETE, 32'd0);      // delete from empty table
    send_item(OP_INSERT, KEY_MIN);
    send_item(OP_INSERT, KEY_MIN);    // single repeated key
    send_item(OP_INSERT, KEY_MAX);
    send_item(OP_DELETE, KEY_MIN);
    send_item(OP_DELETE, KEY_MIN);    // count reaches zero, entry freed
    send_item(OP_DELETE, KEY_MIN);    // absent key with others present
    send_item(OP_INSERT, KEY_ALL_ONES); // reuses the lowest free entry
    send_item(OP_INSERT, 32'd0);
    send_item(OP_INSERT, 32'd0);
    send_item(OP_INSERT, 32'h7fff_fffe); // one bit away from a live key
    send_item(OP_DELETE, KEY_MAX);
    send_item(OP_DELETE, 32'h7fff_fffe);
    send_item(OP_DELETE, KEY_ALL_ONES);
    send_item(OP_DELETE, 32'd0);
    send_item(OP_DELETE, 32'd0);
    send_item(OP_INSERT, 32'h5555_5555);
    send_item(OP_INSERT, 32'haaaa_aaaa);
    send_item(OP_DELETE, 32'h5555_5555);
    send_item(OP_DELETE, 32'haaaa_aaaa);
    hold_until_drained();

    run_random(17, 84, 460);
    hold_until_drained();
    run_random(84, 17, 460);
    hold_until_drained();
    run_random(0, 0, 460);
    hold_until_drained();

    // Empty the table, then a short repeated-key sequence.
    while (mirror.distinct_keys > 0) send_item(OP_DELETE, mirror.pick_key());
    send_item(OP_INSERT, KEY_MIN);
    send_item(OP_INSERT, KEY_MIN);
    send_item(OP_INSERT, 32'd5);
    send_item(OP_DELETE, KEY_MIN);
    send_item(OP_DELETE, 32'd5);

    in_valid <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mirror.pending() != 0) begin
      $display("%0t: %0d results never arrived", $time, mirror.pending());
      mirror.errors += mirror.pending();
    end
    $display("Run: %0d transfers in, %0d results checked, %0d with overflow set",
             items_sent, mirror.results, mirror.overflows);
    $display("Classes seen neither/homo/hetero/both: %0d/%0d/%0d/%0d, %0d mismatches",
             mirror.class_seen[0], mirror.class_seen[1], mirror.class_seen[2],
             mirror.class_seen[3], mirror.errors);
    if (mirror.errors == 0) begin
      $display("multiset_duplicate_classifier verification clean");
    end else begin
      $display("multiset_duplicate_classifier verification failed");
    end
    $finish;
  end
endmodule
